/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/slw_pkg.sv */
// ---------------------------------------------------------------------------
// slw_pkg
// Shared constants and types of the LIKE wildcard matcher.
// ---------------------------------------------------------------------------
package slw_pkg;

  // largest pattern the row of cells is built for
  localparam int PATTERN_MAX_DEF = 16;

  // pattern metacharacters
  localparam logic [7:0] LIKE_ANY_ONE = 8'h5F;
  localparam logic [7:0] LIKE_ANY_RUN = 8'h25;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_REG_W   = 5;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PATTERN_LENGTH = 2'd0;
  localparam cfg_index_t REG_PATTERN_LOW    = 2'd1;
  localparam cfg_index_t REG_PATTERN_HIGH   = 2'd2;

  typedef logic [7:0] byte_t;

endpackage

/* rtl/slw_if.sv */
// ---------------------------------------------------------------------------
// slw_if
// Valid/ready channels of the LIKE wildcard matcher: text in, match out,
// configuration writes.
// ---------------------------------------------------------------------------
interface slw_text_if;
  import slw_pkg::*;
  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  last_byte;
  logic  empty_string;
  modport source (output valid, text_byte, last_byte, empty_string, input ready);
  modport sink   (input valid, text_byte, last_byte, empty_string, output ready);
endinterface

interface slw_match_if;
  logic valid;
  logic ready;
  logic matched;
  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

interface slw_cfg_if;
  import slw_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/slw_cell.sv */
// ---------------------------------------------------------------------------
// slw_cell
// One pattern position: holds its active bit, passes the '%' closure and
// the one-byte advance on to the next position.
// ---------------------------------------------------------------------------
module slw_cell #(
  parameter bit IS_FIRST = 1'b0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          ends,
  input  slw_pkg::byte_t pat_byte,
  input  slw_pkg::byte_t text_byte,
  input  logic          in_use,
  input  logic          carry_in,
  input  logic          shift_in,
  output logic          carry_out,
  output logic          shift_out,
  output logic          run_flag,
  output logic          cur_bit,
  output logic          adv_bit
);
  import slw_pkg::*;

  logic active;
  logic closed;
  logic hit;
  logic is_run;
  logic is_one;

  // closure and advance for this position
  always_comb begin
    closed    = active | carry_in;
    hit       = closed & in_use;
    is_run    = (pat_byte == LIKE_ANY_RUN);
    is_one    = (pat_byte == LIKE_ANY_ONE) || (pat_byte == text_byte);
    run_flag  = in_use & is_run;
    carry_out = hit & is_run;
    shift_out = hit & ~is_run & is_one;
    adv_bit   = (hit & is_run) | shift_in;
    cur_bit   = active;
  end

  // active bit, back to the start set when a string ends
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= IS_FIRST;
    end else if (take) begin
      active <= ends ? IS_FIRST : adv_bit;
    end
  end

endmodule

/* rtl/slw_accept.sv */
// ---------------------------------------------------------------------------
// slw_accept
// Final '%' closure over a finished active set and pick of the bit at the
// pattern length.
// ---------------------------------------------------------------------------
module slw_accept #(
  parameter int PATTERN_MAX = slw_pkg::PATTERN_MAX_DEF,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX:0]   set_bits,
  input  logic [PATTERN_MAX-1:0] run_flags,
  input  logic [LEN_W-1:0]       used_len,
  output logic                   matched
);
  import slw_pkg::*;

  logic [PATTERN_MAX:0] clos;

  // ripple of '%' skips along the positions
  always_comb begin
    clos[0] = set_bits[0];
    for (int i = 0; i < PATTERN_MAX; i++) begin
      clos[i+1] = set_bits[i+1] | (clos[i] & run_flags[i]);
    end
    matched = (used_len == '0) | clos[used_len];
  end

endmodule

/* rtl/sql_like_wildcard_matcher.sv */
// ---------------------------------------------------------------------------
// sql_like_wildcard_matcher
// SQL LIKE matcher over a byte stream, pattern held in configuration.
// ---------------------------------------------------------------------------
// Takes one text byte per clock cycle while the output is not stalled,
// string after string with no gap. A row of PATTERN_MAX cells keeps one
// active bit per pattern position and updates it for each byte; the cycle
// time is set by the '%' skip ripple along that row. The item that ends a
// string (last_byte, or empty_string, which adds no byte) gives one match
// bit through an evaluation register and then an output register, so up to
// two results can be in flight while the output stalls. An empty pattern
// matches every string; a length above PATTERN_MAX counts as PATTERN_MAX.
// Configuration is taken in any cycle and acts from the next item on; the
// evaluation stage reads the live pattern, so write it only while no result
// is pending. There is no clearing pass after reset.
module sql_like_wildcard_matcher #(
  parameter int PATTERN_MAX = slw_pkg::PATTERN_MAX_DEF
) (
  input logic          clk,
  input logic          rst,
  slw_cfg_if.sink      cfg,
  slw_text_if.sink     text,
  slw_match_if.source  result
);
  import slw_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  // configuration registers
  logic [LEN_REG_W-1:0]  pattern_length;
  logic [CFG_DATA_W-1:0] pattern_bytes_low;
  logic [CFG_DATA_W-1:0] pattern_bytes_high;

  logic [2*CFG_DATA_W-1:0] pattern_all;
  logic [LEN_W-1:0]        used_len;

  // cell row
  logic [PATTERN_MAX:0]   carry;
  logic [PATTERN_MAX:0]   shift;
  logic [PATTERN_MAX-1:0] run_flags;
  logic [PATTERN_MAX-1:0] cur_bits;
  logic [PATTERN_MAX-1:0] adv_bits;
  logic                   top_bit;

  // pipeline
  logic                 take;
  logic                 ends;
  logic                 out_free;
  logic                 eval_valid;
  logic [PATTERN_MAX:0] eval_set;
  logic                 eval_matched;
  logic                 res_valid;
  logic                 res_matched;

  // configuration write transfer
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= '0;
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PATTERN_LENGTH: pattern_length     <= cfg.data[LEN_REG_W-1:0];
        REG_PATTERN_LOW:    pattern_bytes_low  <= cfg.data;
        REG_PATTERN_HIGH:   pattern_bytes_high <= cfg.data;
        default: ;
      endcase
    end
  end

  // clamp the length to the row size
  always_comb begin
    pattern_all = {pattern_bytes_high, pattern_bytes_low};
    if (pattern_length > LEN_REG_W'(PATTERN_MAX)) begin
      used_len = LEN_W'(PATTERN_MAX);
    end else begin
      used_len = pattern_length[LEN_W-1:0];
    end
  end

  // handshake and pipeline control
  assign out_free     = ~res_valid | result.ready;
  assign text.ready   = ~eval_valid | out_free;
  assign take         = text.valid & text.ready;
  assign ends         = text.last_byte | text.empty_string;
  assign result.valid   = res_valid;
  assign result.matched = res_matched;

  assign carry[0] = 1'b0;
  assign shift[0] = 1'b0;

  // one cell per pattern position
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    slw_cell #(
      .IS_FIRST (i == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .take      (take),
      .ends      (ends),
      .pat_byte  (pattern_all[i*8 +: 8]),
      .text_byte (text.text_byte),
      .in_use    (used_len > LEN_W'(i)),
      .carry_in  (carry[i]),
      .shift_in  (shift[i]),
      .carry_out (carry[i+1]),
      .shift_out (shift[i+1]),
      .run_flag  (run_flags[i]),
      .cur_bit   (cur_bits[i]),
      .adv_bit   (adv_bits[i])
    );
  end

  // end-of-pattern position, reached only by a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      top_bit <= 1'b0;
    end else if (take) begin
      top_bit <= ends ? 1'b0 : shift[PATTERN_MAX];
    end
  end

  // evaluation stage: the set of the finished string
  always_ff @(posedge clk) begin
    if (rst) begin
      eval_valid <= 1'b0;
    end else if (text.ready) begin
      eval_valid <= take & ends;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ends) begin
      if (text.empty_string) begin
        eval_set <= {top_bit, cur_bits};
      end else begin
        eval_set <= {shift[PATTERN_MAX], adv_bits};
      end
    end
  end

  slw_accept #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_accept (
    .set_bits  (eval_set),
    .run_flags (run_flags),
    .used_len  (used_len),
    .matched   (eval_matched)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= eval_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && eval_valid) begin
      res_matched <= eval_matched;
    end
  end

endmodule

/* rtl/slw_checker.sv */
// ---------------------------------------------------------------------------
// slw_checker
// Port-level checks of the LIKE wildcard matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input slw_pkg::cfg_index_t           cfg_index,
  input logic [slw_pkg::CFG_DATA_W-1:0] cfg_data,
  input logic                          text_valid,
  input logic                          text_ready,
  input logic                          text_last,
  input logic                          text_empty,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          res_matched
);
  import slw_pkg::*;

  logic [LEN_REG_W-1:0] shadow_len;
  logic [1:0]           pending;
  logic                 str_done;
  logic                 res_done;

  assign str_done = text_valid & text_ready & (text_last | text_empty);
  assign res_done = res_valid & res_ready;

  // pattern length as last written
  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_len <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index == REG_PATTERN_LENGTH) begin
      shadow_len <= cfg_data[LEN_REG_W-1:0];
    end
  end

  // finished strings whose result is not yet out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(str_done) - 2'(res_done);
    end
  end

  `ASSERT_NEXT(a_result_holds, clk, rst, res_valid && !res_ready, res_valid && $stable(res_matched))
  `ASSERT_IMPLIES(a_stall_only_on_full, clk, rst, !text_ready, res_valid && !res_ready)
  `ASSERT_IMPLIES(a_result_has_string, clk, rst, res_valid, pending != 2'd0)
  `ASSERT_IMPLIES(a_empty_pattern_matches, clk, rst, res_valid && shadow_len == '0, res_matched)

endmodule

bind sql_like_wildcard_matcher slw_checker u_slw_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_valid   (cfg.valid),
  .cfg_ready   (cfg.ready),
  .cfg_index   (cfg.index),
  .cfg_data    (cfg.data),
  .text_valid  (text.valid),
  .text_ready  (text.ready),
  .text_last   (text.last_byte),
  .text_empty  (text.empty_string),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_matched (result.matched)
);

/* sim/sql_like_wildcard_matcher_tb.sv */
// ---------------------------------------------------------------------------
// sql_like_wildcard_matcher_tb
// Self-checking bench for the LIKE matcher. A scoreboard keeps its own copy
// of the pattern and of the active position set. Each text transfer is
// predicted as it is accepted, and each match transfer is checked against
// the oldest prediction. Directed strings cover the corner cases. Random
// patterns follow, each with strings built mostly to fit the pattern.
// Random idle gaps are applied on both sides.
// ---------------------------------------------------------------------------
module sql_like_wildcard_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slw_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 550;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int SET_W         = PATTERN_MAX_DEF + 1;

  // index with no register behind it
  localparam cfg_index_t REG_UNUSED = 2'd3;

  typedef byte_t text_q[$];

  // predicts the match bit of every finished string and checks the output
  class match_scoreboard;
    logic [LEN_REG_W-1:0]  pat_len;
    logic [CFG_DATA_W-1:0] pat_low;
    logic [CFG_DATA_W-1:0] pat_high;
    logic [SET_W-1:0]      active;
    bit                    expected_matches[$];
    int                    errors;

    function new();
      pat_len  = '0;
      pat_low  = '0;
      pat_high = '0;
      active   = SET_W'(1);
      errors   = 0;
    endfunction

    // pattern length in use, clamped to the row size
    function int span();
      return (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
    endfunction

    function byte_t pat_byte(int i);
      logic [CFG_DATA_W-1:0] w;
      w = (i < 8) ? pat_low : pat_high;
      return w[(i % 8) * 8 +: 8];
    endfunction

    // a live position in front of '%' also makes the next one live
    function logic [SET_W-1:0] skip_closure(logic [SET_W-1:0] s, int n);
      for (int i = 0; i < n; i++) begin
        if (s[i] && pat_byte(i) == LIKE_ANY_RUN) s[i+1] = 1'b1;
      end
      return s;
    endfunction

    function logic [SET_W-1:0] next_positions(logic [SET_W-1:0] s, int n, byte_t c);
      logic [SET_W-1:0] nxt;
      byte_t            p;
      nxt = '0;
      s = skip_closure(s, n);
      for (int i = 0; i < n; i++) begin
        if (s[i]) begin
          p = pat_byte(i);
          if (p == LIKE_ANY_RUN) nxt[i] = 1'b1;
          else if (p == LIKE_ANY_ONE || p == c) nxt[i+1] = 1'b1;
        end
      end
      return nxt;
    endfunction

    function bit string_matches(logic [SET_W-1:0] s, int n);
      logic [SET_W-1:0] full;
      if (n == 0) return 1'b1;
      full = skip_closure(s, n);
      return full[n];
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_PATTERN_LENGTH: pat_len = d[LEN_REG_W-1:0];
        REG_PATTERN_LOW:    pat_low = d;
        REG_PATTERN_HIGH:   pat_high = d;
        default: ;
      endcase
    endfunction

    // empty_string wins over last_byte and adds no byte
    function void note_text(byte_t c, logic last, logic empty);
      int n;
      n = span();
      if (empty) begin
        expected_matches.insert(expected_matches.size(), string_matches(active, n));
        active = SET_W'(1);
      end else begin
        active = next_positions(active, n, c);
        if (last) begin
          expected_matches.insert(expected_matches.size(), string_matches(active, n));
          active = SET_W'(1);
        end
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_match(logic got);
      bit want;
      if (expected_matches.size() == 0) begin
        report($sformatf("matched=%b with no string pending", got));
      end else begin
        want = expected_matches.pop_front();
        if (got !== want) report($sformatf("matched=%b, want %b", got, want));
      end
    endtask

    function int pending();
      return expected_matches.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  slw_cfg_if   cfg_bus();
  slw_text_if  text_bus();
  slw_match_if match_bus();

  sql_like_wildcard_matcher u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .text   (text_bus),
    .result (match_bus)
  );

  match_scoreboard sb = new();

  logic [LEN_REG_W-1:0] cur_len;
  logic [127:0]         cur_pat;
  int                   items_sent;
  int                   results_seen;
  int                   cycle_count;
  bit                   tx_calm;
  bit                   rx_calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL sql_like_wildcard_matcher");
    $finish;
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int idle_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // match side: random stalls plus two long holds while text keeps coming
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    results_seen = 0;
    rx_calm = 1'b0;
    match_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && match_bus.valid && match_bus.ready) begin
        sb.check_match(match_bus.matched);
        results_seen++;
        if (results_seen == 40 || results_seen == 100) hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (hold_left > 0) begin
        hold_left--;
        match_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        match_bus.ready <= 1'b0;
      end else begin
        match_bus.ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) stall_left = idle_gap(rx_calm);
      end
    end
  end

  // one text transfer; valid stays high for a back-to-back follower
  task automatic send_text(byte_t c, logic last, logic empty);
    int gap;
    gap = idle_gap(tx_calm);
    if (gap > 0) begin
      text_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_bus.valid        <= 1'b1;
    text_bus.text_byte    <= c;
    text_bus.last_byte    <= last;
    text_bus.empty_string <= empty;
    do @(posedge clk); while (!text_bus.ready);
    sb.note_text(c, last, empty);
    items_sent++;
  endtask

  // a whole string; optionally ended by an empty item instead of last_byte
  task automatic send_string(text_q s, bit end_by_empty);
    if (s.size() == 0) begin
      send_text(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else begin
      foreach (s[i]) send_text(s[i], !end_by_empty && i == s.size() - 1, 1'b0);
      if (end_by_empty)
        send_text(byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  // register write once the block has drained
  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] d);
    text_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, d);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_pattern(logic [LEN_REG_W-1:0] len, logic [127:0] pat);
    cur_len = len;
    cur_pat = pat;
    write_reg(REG_PATTERN_LOW, pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
  endtask

  // text byte: mostly a small alphabet, some wildcard chars, some anything
  function automatic byte_t pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'h61 + byte_t'($urandom_range(0, 2));
    if (r < 80) return $urandom_range(0, 1) ? LIKE_ANY_RUN : LIKE_ANY_ONE;
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic random_pattern();
    logic [127:0]         pat;
    logic [LEN_REG_W-1:0] len;
    int                   r;
    for (int i = 0; i < 16; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) pat[i*8 +: 8] = 8'h61 + byte_t'($urandom_range(0, 2));
      else if (r < 65) pat[i*8 +: 8] = LIKE_ANY_RUN;
      else if (r < 85) pat[i*8 +: 8] = LIKE_ANY_ONE;
      else pat[i*8 +: 8] = byte_t'($urandom_range(0, 255));
    end
    r = $urandom_range(0, 99);
    if (r < 10) len = '0;
    else if (r < 80) len = LEN_REG_W'($urandom_range(1, 6));
    else if (r < 92) len = LEN_REG_W'($urandom_range(7, 16));
    else len = LEN_REG_W'($urandom_range(17, 31));
    set_pattern(len, pat);
  endtask

  // string that fits the current pattern, sometimes damaged, else noise
  function automatic text_q make_text();
    text_q s;
    int    n;
    int    pos;
    byte_t p;
    s = {};
    n = (cur_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(cur_len);
    if ($urandom_range(0, 99) < 70) begin
      for (int i = 0; i < n; i++) begin
        p = cur_pat[i*8 +: 8];
        if (p == LIKE_ANY_RUN) repeat ($urandom_range(0, 2)) s.insert(s.size(), pick_char());
        else if (p == LIKE_ANY_ONE) s.insert(s.size(), pick_char());
        else s.insert(s.size(), p);
      end
      if ($urandom_range(0, 99) < 35) begin
        pos = (s.size() == 0) ? 0 : $urandom_range(0, s.size() - 1);
        case ($urandom_range(0, 2))
          0: if (s.size() > 0) s[pos] = pick_char();
          1: if (s.size() > 0) s.delete(pos);
          default: s.insert(pos, pick_char());
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 6)) s.insert(s.size(), pick_char());
    end
    return s;
  endfunction

  // stimulus
  initial begin
    int start;
    rst                   <= 1'b1;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= REG_PATTERN_LENGTH;
    cfg_bus.data          <= '0;
    text_bus.valid        <= 1'b0;
    text_bus.text_byte    <= '0;
    text_bus.last_byte    <= 1'b0;
    text_bus.empty_string <= 1'b0;
    items_sent = 0;
    tx_calm = 1'b0;
    cur_len = '0;
    cur_pat = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty pattern after reset: everything matches
    send_text(8'h00, 1'b0, 1'b1);
    send_text(8'hFF, 1'b1, 1'b0);

    // pattern a%b
    set_pattern(5'd3, 128'({8'h62, LIKE_ANY_RUN, 8'h61}));
    send_string({8'h61, 8'h62}, 1'b0);
    // a '%' in the text is only data for the wildcard
    send_string({8'h61, LIKE_ANY_RUN, 8'h78, 8'h62}, 1'b0);
    send_string({8'h61}, 1'b0);
    // both flags: empty string wins, byte ignored
    send_text(8'hFF, 1'b1, 1'b1);
    // string ended by an empty item
    send_string({8'h61, 8'h62}, 1'b1);

    // new pattern a_ while the string is open
    send_text(8'h61, 1'b0, 1'b0);
    set_pattern(5'd2, 128'({LIKE_ANY_ONE, 8'h61}));
    send_text(8'h7A, 1'b1, 1'b0);

    // length above the row size is clamped
    set_pattern(5'd31, {16{LIKE_ANY_RUN}});
    send_text(8'hFF, 1'b1, 1'b0);
    send_text(8'h00, 1'b0, 1'b1);
    set_pattern(5'd31, {8'h00, {15{LIKE_ANY_RUN}}});
    send_string({8'hFF, 8'h00}, 1'b0);
    send_text(8'hFF, 1'b1, 1'b0);

    // write to an unused index has no effect
    write_reg(REG_UNUSED, '1);
    send_text(8'h00, 1'b1, 1'b0);

    // random patterns, strings mostly shaped by the pattern
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      random_pattern();
      repeat ($urandom_range(4, 14)) begin
        if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
        send_string(make_text(), $urandom_range(0, 9) == 0);
      end
    end

    // drain and finish
    text_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS sql_like_wildcard_matcher");
    end else begin
      $display("FAIL sql_like_wildcard_matcher");
    end
    $finish;
  end

endmodule
